// ===== hw/rtl/rgtp_pkg.sv =====
// Package for the rectangle grid test pattern unit.
// Holds the field widths, the color channel layout and the register index codes.
// Used by the channel interfaces and by the top level.
`timescale 1ns / 1ps
`default_nettype none

package rgtp_pkg;

	localparam int RED_BITS   = 8;
	localparam int GREEN_BITS = 8;
	localparam int BLUE_BITS  = 8;
	localparam int INDEX_BITS = 8;
	localparam int COORD_BITS = 12;

	localparam int XY_W    = 12;
	localparam int GRID_W  = 8;
	localparam int COLOR_W = 24;
	localparam int STEP_W  = 8;
	localparam int LIM_W   = XY_W + GRID_W;
	localparam int LIN_W   = 2 * GRID_W;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 24;
	localparam int DIV_STAGES = GRID_W;

	localparam logic [XY_W-1:0] COORD_MASK = XY_W'((64'd1 << COORD_BITS) - 64'd1);
	localparam logic [COLOR_W-1:0] INDEX_MASK = COLOR_W'((64'd1 << INDEX_BITS) - 64'd1);

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COUNT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_COLOR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_STEP    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INDEXED_MODE  = 3'd5;

endpackage

`default_nettype wire

// ===== hw/rtl/rgtp_if.sv =====
// Request channels of the rectangle grid test pattern unit.
// One interface carries pixel coordinates, the other carries pixel colors.
// Depends on rgtp_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rgtp_px_if;
	logic                      valid;
	logic                      ready;
	logic [rgtp_pkg::XY_W-1:0] pixel_x;
	logic [rgtp_pkg::XY_W-1:0] pixel_y;

	modport source(output valid, output pixel_x, output pixel_y, input ready);
	modport sink(input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface rgtp_res_if;
	logic                         valid;
	logic                         ready;
	logic [rgtp_pkg::COLOR_W-1:0] pixel_color;
	logic                         on_screen;
	logic                         in_grid;

	modport source(output valid, output pixel_color, output on_screen, output in_grid,
		input ready);
	modport sink(input valid, input pixel_color, input on_screen, input in_grid,
		output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rectangle_grid_test_pattern_unit.sv =====
// Throughput: one pixel per cycle while the result side is not stalled and no cell size
// rebuild or register write is under way; the column and row come from an 8 stage
// restoring divider, one quotient bit per stage, followed by two color stages.
// Reset empties the pipeline and loads the register reset values. After reset and after
// a write to width, height or grid count, the cell size is rebuilt by a load state, the
// serial divider state and a multiply state; no pixel is taken then.
`timescale 1ns / 1ps
`default_nettype none

module rectangle_grid_test_pattern_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [rgtp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rgtp_pkg::CFG_W-1:0]     cfg_data,
	rgtp_px_if.sink                             pixel,
	rgtp_res_if.source                          result
);
	import rgtp_pkg::*;

	localparam int CNT_W = $clog2(XY_W);
	localparam int GB_SHIFT = GREEN_BITS + BLUE_BITS;

	typedef enum logic [1:0] {S_LOAD, S_DIV, S_MUL, S_IDLE} seq_state_t;

	logic [XY_W-1:0]    screen_width_q;
	logic [XY_W-1:0]    screen_height_q;
	logic [GRID_W-1:0]  grid_count_q;
	logic [COLOR_W-1:0] first_color_q;
	logic [STEP_W-1:0]  color_step_q;
	logic               indexed_mode_q;

	seq_state_t         state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [XY_W-1:0]    wq_q;
	logic [XY_W-1:0]    hq_q;
	logic [GRID_W-1:0]  wr_q;
	logic [GRID_W-1:0]  hr_q;
	logic [XY_W-1:0]    cw_q;
	logic [XY_W-1:0]    ch_q;
	logic [LIM_W-1:0]   limx_q;
	logic [LIM_W-1:0]   limy_q;
	logic [GRID_W:0]    w_trial;
	logic [GRID_W:0]    h_trial;
	logic               w_ge;
	logic               h_ge;
	logic               geom_write;
	logic               cfg_idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= XY_W'(1024);
			screen_height_q <= XY_W'(768);
			grid_count_q    <= GRID_W'(1);
			first_color_q   <= '0;
			color_step_q    <= STEP_W'(1);
			indexed_mode_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data[XY_W-1:0];
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data[XY_W-1:0];
				REG_GRID_COUNT:    grid_count_q    <= cfg_data[GRID_W-1:0];
				REG_FIRST_COLOR:   first_color_q   <= cfg_data[COLOR_W-1:0];
				REG_COLOR_STEP:    color_step_q    <= cfg_data[STEP_W-1:0];
				REG_INDEXED_MODE:  indexed_mode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign geom_write = cfg_we && (cfg_index == REG_SCREEN_WIDTH ||
		cfg_index == REG_SCREEN_HEIGHT || cfg_index == REG_GRID_COUNT);
	assign cfg_idle = (state_q == S_IDLE);

	always_comb begin
		w_trial = {wr_q, wq_q[XY_W-1]};
		h_trial = {hr_q, hq_q[XY_W-1]};
		w_ge = (w_trial >= {1'b0, grid_count_q});
		h_ge = (h_trial >= {1'b0, grid_count_q});
	end

	// Cell size is width / count and height / count, one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q   <= '0;
		end else if (geom_write) begin
			state_q <= S_LOAD;
		end else begin
			case (state_q)
				S_LOAD: begin
					wq_q    <= screen_width_q;
					hq_q    <= screen_height_q;
					wr_q    <= '0;
					hr_q    <= '0;
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					wr_q  <= w_ge ? GRID_W'(w_trial - {1'b0, grid_count_q}) : GRID_W'(w_trial);
					hr_q  <= h_ge ? GRID_W'(h_trial - {1'b0, grid_count_q}) : GRID_W'(h_trial);
					wq_q  <= {wq_q[XY_W-2:0], w_ge};
					hq_q  <= {hq_q[XY_W-2:0], h_ge};
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(XY_W - 1)) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					cw_q    <= wq_q;
					ch_q    <= hq_q;
					limx_q  <= LIM_W'(wq_q) * LIM_W'(grid_count_q);
					limy_q  <= LIM_W'(hq_q) * LIM_W'(grid_count_q);
					state_q <= S_IDLE;
				end
				S_IDLE: ;
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// Pixel pipeline: entry stage at index 0, then one divider stage per quotient bit.
	logic                advance;
	logic                accept;
	logic [XY_W-1:0]     x_in;
	logic [XY_W-1:0]     y_in;
	logic                on_in;
	logic                grid_in;

	logic                v_sn    [DIV_STAGES+1];
	logic                on_sn   [DIV_STAGES+1];
	logic                grid_sn [DIV_STAGES+1];
	logic [XY_W-1:0]     xrem_sn [DIV_STAGES+1];
	logic [XY_W-1:0]     yrem_sn [DIV_STAGES+1];
	logic [GRID_W-1:0]   col_sn  [DIV_STAGES+1];
	logic [GRID_W-1:0]   row_sn  [DIV_STAGES+1];

	assign advance = !result.valid || result.ready;
	assign pixel.ready = advance && cfg_idle && !cfg_we;
	assign accept = pixel.valid && pixel.ready;

	always_comb begin
		x_in = pixel.pixel_x & COORD_MASK;
		y_in = pixel.pixel_y & COORD_MASK;
		on_in = (x_in < screen_width_q) && (y_in < screen_height_q);
		grid_in = on_in && (grid_count_q != '0) && (cw_q != '0) && (ch_q != '0) &&
			(LIM_W'(x_in) < limx_q) && (LIM_W'(y_in) < limy_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sn[0] <= 1'b0;
		end else if (advance) begin
			v_sn[0] <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			on_sn[0]   <= on_in;
			grid_sn[0] <= grid_in;
			xrem_sn[0] <= x_in;
			yrem_sn[0] <= y_in;
			col_sn[0]  <= '0;
			row_sn[0]  <= '0;
		end
	end

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
		localparam int SH = DIV_STAGES - 1 - j;
		logic [LIM_W-1:0] dx;
		logic [LIM_W-1:0] dy;
		logic             gx;
		logic             gy;

		always_comb begin
			dx = LIM_W'(cw_q) << SH;
			dy = LIM_W'(ch_q) << SH;
			gx = (LIM_W'(xrem_sn[j]) >= dx);
			gy = (LIM_W'(yrem_sn[j]) >= dy);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sn[j+1] <= 1'b0;
			end else if (advance) begin
				v_sn[j+1] <= v_sn[j];
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				on_sn[j+1]   <= on_sn[j];
				grid_sn[j+1] <= grid_sn[j];
				xrem_sn[j+1] <= gx ? XY_W'(LIM_W'(xrem_sn[j]) - dx) : xrem_sn[j];
				yrem_sn[j+1] <= gy ? XY_W'(LIM_W'(yrem_sn[j]) - dy) : yrem_sn[j];
				col_sn[j+1]  <= {col_sn[j][GRID_W-2:0], gx};
				row_sn[j+1]  <= {row_sn[j][GRID_W-2:0], gy};
			end
		end
	end

	// Color stage: cell number and channel offsets, then the final color.
	logic               v_s10;
	logic               on_s10;
	logic               grid_s10;
	logic [LIN_W-1:0]   lin_s10;
	logic [LIN_W-1:0]   cs_s10;
	logic [LIN_W-1:0]   rs_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (advance) begin
			v_s10 <= v_sn[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			on_s10   <= on_sn[DIV_STAGES];
			grid_s10 <= grid_sn[DIV_STAGES];
			lin_s10  <= LIN_W'(row_sn[DIV_STAGES]) * LIN_W'(grid_count_q) +
				LIN_W'(col_sn[DIV_STAGES]);
			cs_s10   <= LIN_W'(col_sn[DIV_STAGES]) * LIN_W'(color_step_q);
			rs_s10   <= LIN_W'(row_sn[DIV_STAGES]) * LIN_W'(color_step_q);
		end
	end

	logic [COLOR_W-1:0]    idx_color;
	logic [RED_BITS-1:0]   red;
	logic [GREEN_BITS-1:0] green;
	logic [BLUE_BITS-1:0]  blue;
	logic [COLOR_W-1:0]    rgb_color;
	logic [COLOR_W-1:0]    color_next;

	always_comb begin
		idx_color = (first_color_q + COLOR_W'(lin_s10) * COLOR_W'(color_step_q)) & INDEX_MASK;
		red   = RED_BITS'(32'(first_color_q >> GB_SHIFT) + 32'(cs_s10));
		green = GREEN_BITS'(32'(first_color_q >> BLUE_BITS) + 32'(rs_s10));
		blue  = BLUE_BITS'(32'(first_color_q) + 32'(cs_s10) + 32'(rs_s10));
		rgb_color = COLOR_W'({red, green, blue});
		color_next = grid_s10 ? (indexed_mode_q ? idx_color : rgb_color) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.valid <= 1'b0;
		end else if (advance) begin
			result.valid <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result.pixel_color <= color_next;
			result.on_screen   <= on_s10;
			result.in_grid     <= grid_s10;
		end
	end

	a_ready_needs_cell_size: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.ready |-> cfg_idle)
		else $error("pixel taken while the cell size is being rebuilt");

	a_geometry_write_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		geom_write |=> !pixel.ready)
		else $error("pixel taken right after a geometry write");

	a_grid_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.in_grid) |-> result.on_screen)
		else $error("grid pixel reported off screen");

	a_border_black: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.in_grid) |-> (result.pixel_color == '0))
		else $error("border or off screen pixel is not black");

endmodule

`default_nettype wire

// ===== tb/sv/rectangle_grid_test_pattern_unit_test.sv =====
// Self-checking testbench for the rectangle grid test pattern unit.
// A scoreboard class predicts the color, on-screen and grid flags of every pixel request.
// Depends on rgtp_pkg, the rgtp_px_if and rgtp_res_if interfaces and the unit itself.
`timescale 1ns / 1ps

module rectangle_grid_test_pattern_unit_test;
	import rgtp_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int RAND_PHASES   = 19;
	localparam int PHASE_ITEMS   = 100;
	localparam int SQUEEZE_PHASE = 5;
	localparam int STEADY_FROM   = 16;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 16;

	typedef struct packed {
		logic [COLOR_W-1:0] pixel_color;
		logic               on_screen;
		logic               in_grid;
	} pixel_shade_t;

	class grid_shade_board;
		logic [XY_W-1:0]    scr_w;
		logic [XY_W-1:0]    scr_h;
		logic [GRID_W-1:0]  grid_n;
		logic [COLOR_W-1:0] base_color;
		logic [STEP_W-1:0]  color_step;
		logic               indexed;
		pixel_shade_t       pending_shades[$];
		int                 errors;

		function new();
			scr_w      = XY_W'(1024);
			scr_h      = XY_W'(768);
			grid_n     = GRID_W'(1);
			base_color = '0;
			color_step = STEP_W'(1);
			indexed    = 1'b1;
			errors     = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_SCREEN_WIDTH:  scr_w = data[XY_W-1:0];
				REG_SCREEN_HEIGHT: scr_h = data[XY_W-1:0];
				REG_GRID_COUNT:    grid_n = data[GRID_W-1:0];
				REG_FIRST_COLOR:   base_color = data[COLOR_W-1:0];
				REG_COLOR_STEP:    color_step = data[STEP_W-1:0];
				REG_INDEXED_MODE:  indexed = data[0];
				default: ;
			endcase
		endfunction

		function void note_pixel(logic [XY_W-1:0] x, logic [XY_W-1:0] y);
			int unsigned xu, yu, n, stp, bu, cw, ch, col, row, v, r, g, b;
			int unsigned rm, gm, bm;
			longint unsigned pk;
			pixel_shade_t s;
			s = '0;
			xu = x & COORD_MASK;
			yu = y & COORD_MASK;
			n = grid_n;
			stp = color_step;
			bu = base_color;
			if (xu < scr_w && yu < scr_h) begin
				s.on_screen = 1'b1;
				if (n != 0) begin
					cw = int'(scr_w) / n;
					ch = int'(scr_h) / n;
					if (cw != 0 && ch != 0) begin
						col = xu / cw;
						row = yu / ch;
						if (col < n && row < n) begin
							s.in_grid = 1'b1;
							if (indexed) begin
								v = (bu + (row * n + col) * stp) & ((32'd1 << INDEX_BITS) - 1);
							end else begin
								rm = (32'd1 << RED_BITS) - 1;
								gm = (32'd1 << GREEN_BITS) - 1;
								bm = (32'd1 << BLUE_BITS) - 1;
								r = (((bu >> (GREEN_BITS + BLUE_BITS)) & rm) + col * stp) & rm;
								g = (((bu >> BLUE_BITS) & gm) + row * stp) & gm;
								b = ((bu & bm) + (col + row) * stp) & bm;
								pk = (longint'(r) << (GREEN_BITS + BLUE_BITS)) |
									(longint'(g) << BLUE_BITS) | longint'(b);
								v = pk[31:0];
							end
							s.pixel_color = v[COLOR_W-1:0];
						end
					end
				end
			end
			pending_shades.push_back(s);
		endfunction

		function void check_color(logic [COLOR_W-1:0] c, logic on, logic g);
			pixel_shade_t e;
			if (pending_shades.size() == 0) begin
				$error("unexpected result request: pixel_color %h on_screen %b in_grid %b",
					c, on, g);
				errors++;
				return;
			end
			e = pending_shades.pop_front();
			if (c !== e.pixel_color) begin
				$error("pixel_color expected %h actual %h", e.pixel_color, c);
				errors++;
			end
			if (on !== e.on_screen) begin
				$error("on_screen expected %b actual %b", e.on_screen, on);
				errors++;
			end
			if (g !== e.in_grid) begin
				$error("in_grid expected %b actual %b", e.in_grid, g);
				errors++;
			end
		endfunction

		function int waiting();
			return pending_shades.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	rgtp_px_if  px_ch();
	rgtp_res_if res_ch();

	rectangle_grid_test_pattern_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixel(px_ch),
		.result(res_ch)
	);

	grid_shade_board board;
	bit steady;
	bit squeeze_req;
	int tx_gap_pct;
	int rx_stall_pct;
	int cycle_count;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL rectangle_grid_test_pattern_unit");
			$finish;
		end
	end

	// The receiver checks every accepted result request and stalls in random bursts.
	initial begin
		int hold;
		bit squeezed;
		hold = 0;
		squeezed = 1'b0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready)
				board.check_color(res_ch.pixel_color, res_ch.on_screen, res_ch.in_grid);
			if (squeeze_req && !squeezed) begin
				squeezed = 1'b1;
				hold = HOLD_CYCLES;
			end else if (hold == 0 && !steady && $urandom_range(0, 99) < rx_stall_pct) begin
				hold = $urandom_range(1, 16);
			end
			if (hold > 0) begin
				res_ch.ready <= 1'b0;
				hold--;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		board.set_register(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (board.waiting() != 0)
			@(posedge clk);
	endtask

	// Unused upper bits of every write carry random junk that the unit must drop.
	task automatic apply_config(input int w, input int h, input int n,
			input logic [COLOR_W-1:0] base, input int stp, input bit mode);
		drain();
		write_reg(REG_SCREEN_WIDTH, {12'($urandom()), 12'(w)});
		write_reg(REG_SCREEN_HEIGHT, {12'($urandom()), 12'(h)});
		write_reg(REG_GRID_COUNT, {16'($urandom()), 8'(n)});
		write_reg(REG_FIRST_COLOR, base);
		write_reg(REG_COLOR_STEP, {16'($urandom()), 8'(stp)});
		write_reg(REG_INDEXED_MODE, {23'($urandom()), mode});
		write_reg(REG_SPARE_LO, 24'($urandom()));
		write_reg(REG_SPARE_HI, 24'($urandom()));
	endtask

	task automatic send_pixel(input int x, input int y, input bit last);
		px_ch.valid <= 1'b1;
		px_ch.pixel_x <= XY_W'(x);
		px_ch.pixel_y <= XY_W'(y);
		do
			@(posedge clk);
		while (!px_ch.ready);
		board.note_pixel(XY_W'(x), XY_W'(y));
		if (last) begin
			px_ch.valid <= 1'b0;
		end else if (!steady && $urandom_range(0, 99) < tx_gap_pct) begin
			px_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	initial begin
		int w, h, n, xi, yi, pick, span;
		board = new();
		steady = 1'b0;
		squeeze_req = 1'b0;
		tx_gap_pct = 20;
		rx_stall_pct = 10;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		px_ch.valid <= 1'b0;
		px_ch.pixel_x <= '0;
		px_ch.pixel_y <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Settings after reset.
		send_pixel(0, 0, 0);
		send_pixel(1023, 767, 0);
		send_pixel(1024, 5, 0);
		send_pixel(5, 768, 0);
		send_pixel(4095, 4095, 1);

		// Largest screen and grid, with the right and bottom border strips.
		apply_config(4095, 4095, 255, 24'hFFFFFF, 255, 1'b1);
		send_pixel(0, 0, 0);
		send_pixel(4079, 4079, 0);
		send_pixel(4094, 4094, 0);
		send_pixel(4095, 0, 1);

		// Direct color with every channel wrapping.
		apply_config(4095, 4095, 255, 24'hFFFFFF, 255, 1'b0);
		send_pixel(4079, 4079, 0);
		send_pixel(16, 0, 0);
		send_pixel(0, 16, 1);

		// A grid count of zero leaves only border.
		apply_config(640, 480, 0, 24'h123456, 3, 1'b1);
		send_pixel(0, 0, 0);
		send_pixel(100, 100, 1);

		// Cells narrower or lower than one pixel.
		apply_config(3, 100, 5, 24'h00FF00, 7, 1'b0);
		send_pixel(0, 0, 0);
		send_pixel(2, 2, 1);
		apply_config(100, 4, 5, 24'h0000FF, 7, 1'b1);
		send_pixel(0, 0, 1);

		// A resolution of zero puts every pixel off screen.
		apply_config(0, 10, 1, 24'hABCDEF, 1, 1'b1);
		send_pixel(0, 0, 1);
		apply_config(1, 0, 1, 24'hABCDEF, 1, 1'b0);
		send_pixel(0, 0, 1);

		// Smallest screen.
		apply_config(1, 1, 1, 24'($urandom()), 0, 1'b0);
		send_pixel(0, 0, 0);
		send_pixel(1, 0, 0);
		send_pixel(0, 1, 1);

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case ($urandom_range(0, 9))
				0: w = 4095;
				1: w = $urandom_range(1, 16);
				default: w = $urandom_range(16, 4095);
			endcase
			case ($urandom_range(0, 9))
				0: h = 4095;
				1: h = $urandom_range(1, 16);
				default: h = $urandom_range(16, 4095);
			endcase
			case ($urandom_range(0, 9))
				0: n = 255;
				1: n = 1;
				2: n = $urandom_range(0, 255);
				default: n = $urandom_range(1, 32);
			endcase
			apply_config(w, h, n, 24'($urandom()), $urandom_range(0, 255),
				1'($urandom_range(0, 1)));
			steady = (ph >= STEADY_FROM);
			case ($urandom_range(0, 2))
				0: tx_gap_pct = 0;
				1: tx_gap_pct = 15;
				default: tx_gap_pct = 40;
			endcase
			case ($urandom_range(0, 2))
				0: rx_stall_pct = 0;
				1: rx_stall_pct = 5;
				default: rx_stall_pct = 20;
			endcase
			// The receiver holds off for a long stretch while requests keep coming.
			if (ph == SQUEEZE_PHASE) begin
				tx_gap_pct = 0;
				squeeze_req = 1'b1;
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 15) begin
					xi = $urandom_range(0, 4095);
					yi = $urandom_range(0, 4095);
				end else if (pick < 30) begin
					xi = $urandom_range(0, w - 1);
					yi = $urandom_range(0, h - 1);
					if ($urandom_range(0, 1) == 1) begin
						span = (w > 20) ? 20 : w - 1;
						xi = w - 1 - $urandom_range(0, span);
					end else begin
						span = (h > 20) ? 20 : h - 1;
						yi = h - 1 - $urandom_range(0, span);
					end
				end else if (pick < 40) begin
					xi = w + $urandom_range(0, 2);
					yi = $urandom_range(0, h - 1);
					if ($urandom_range(0, 1) == 1) begin
						xi = $urandom_range(0, w - 1);
						yi = h + $urandom_range(0, 2);
					end
				end else begin
					xi = $urandom_range(0, w - 1);
					yi = $urandom_range(0, h - 1);
				end
				send_pixel(xi, yi, i == PHASE_ITEMS - 1);
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.waiting() == 0) begin
			$display("PASS rectangle_grid_test_pattern_unit");
		end else begin
			$display("FAIL rectangle_grid_test_pattern_unit");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/rgtp_pkg.sv
hw/rtl/rgtp_if.sv
hw/rtl/rectangle_grid_test_pattern_unit.sv
tb/sv/rectangle_grid_test_pattern_unit_test.sv
